// ===== hw/rtl/mat_pkg.sv =====
// Shared types and codes for the MAC association table.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps

package mat_pkg;

  localparam int unsigned MAC_W    = 48;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 4;

  typedef enum logic {
    OP_ASSOC    = 1'b0,
    OP_DISASSOC = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLIENT_ADDED = 3'd0,
    ST_DEST_ADDED   = 3'd1,
    ST_PRESENT      = 3'd2,
    ST_REMOVED      = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // latch the input beat, restart the client walk
    logic cscan;     // walk the client address memory
    logic dstart;    // fetch the destination row, restart the walk
    logic dscan;     // walk the destination addresses of the found client
    logic finish_c;  // commit a client-level outcome and load the result
    logic finish_d;  // commit a destination-level outcome and load the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic c_done;      // last client slot checked this cycle
    logic d_done;      // last destination entry checked this cycle
    logic need_dscan;  // associate of a known client
  } sts_t;

endpackage

// ===== hw/rtl/mat_datapath.sv =====
// Datapath of the MAC association table: address memories, scan counters,
// compare logic and the result register. Depends on mat_pkg.
`timescale 1ns / 1ps

module mat_datapath import mat_pkg::*; #(
  parameter int unsigned CLIENT_SLOTS     = 16,
  parameter int unsigned DESTS_PER_CLIENT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_op_i,
  input  logic [MAC_W-1:0]    in_cmac_i,
  input  logic [MAC_W-1:0]    in_dmac_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [STATUS_W-1:0] res_status_o,
  output logic [SLOT_W-1:0]   res_slot_o,
  output logic [COUNT_W-1:0]  res_count_o
);

  localparam int unsigned CIW   = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int unsigned DIW   = (DESTS_PER_CLIENT > 1) ? $clog2(DESTS_PER_CLIENT) : 1;
  localparam int unsigned DEPTH = CLIENT_SLOTS * DESTS_PER_CLIENT;
  localparam int unsigned DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MAXN  = (CLIENT_SLOTS > DESTS_PER_CLIENT) ?
                                  CLIENT_SLOTS : DESTS_PER_CLIENT;
  localparam int unsigned CTRW  = $clog2(MAXN + 1);
  localparam int unsigned CNTW  = $clog2(DESTS_PER_CLIENT + 1);

  localparam logic [DAW-1:0]       D_STRIDE  = DAW'(DESTS_PER_CLIENT);
  localparam logic [CTRW-1:0]      C_LIMIT   = CTRW'(CLIENT_SLOTS);
  localparam logic [CTRW-1:0]      D_LIMIT   = CTRW'(DESTS_PER_CLIENT);
  localparam logic [CTRW-1:0]      C_LAST    = CTRW'(CLIENT_SLOTS - 1);
  localparam logic [CTRW-1:0]      D_LAST    = CTRW'(DESTS_PER_CLIENT - 1);
  localparam logic [CNTW+3:0]      DFULL_EXT = (CNTW + 4)'(DESTS_PER_CLIENT);
  localparam logic [DESTS_PER_CLIENT-1:0] ROW_ONE = DESTS_PER_CLIENT'(1);

  // Latched item
  logic               op_q;
  logic [MAC_W-1:0]   cmac_q, dmac_q;

  // Walk counter and the read in flight
  logic [CTRW-1:0]    ctr_q;
  logic               pvld_q;
  logic [CTRW-1:0]    pidx_q;

  // Client search results
  logic [CLIENT_SLOTS-1:0] used_q;
  logic               hit_q, free_vld_q;
  logic [CIW-1:0]     slot_q, free_q;

  // Destination search results
  logic               dhit_q, dfree_vld_q;
  logic [DIW-1:0]     dfree_q;
  logic [CNTW-1:0]    cnt_q;

  // Memories and their read registers
  logic [MAC_W-1:0]            caddr_mem [CLIENT_SLOTS];
  logic [MAC_W-1:0]            caddr_rd_q;
  logic [DESTS_PER_CLIENT-1:0] row_mem [CLIENT_SLOTS];
  logic [DESTS_PER_CLIENT-1:0] row_rd_q;
  logic [MAC_W-1:0]            daddr_mem [DEPTH];
  logic [MAC_W-1:0]            daddr_rd_q;

  // Result register
  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [COUNT_W-1:0]  res_count_q;

  logic            c_issue, d_issue;
  logic [CIW-1:0]  c_idx, p_cidx;
  logic [DIW-1:0]  d_idx, p_didx;
  logic [DAW-1:0]  d_raddr;
  logic            p_used, c_match, d_used, d_match;
  logic            alloc, add_dest;
  logic            row_we, daddr_we;
  logic [CIW-1:0]  row_wa;
  logic [DESTS_PER_CLIENT-1:0] row_wd;
  logic [DAW-1:0]  daddr_wa;
  logic [CIW+3:0]  slot_ext, free_ext;
  logic [CNTW+3:0] cnt_ext, cnt_inc_ext;

  assign c_issue = cmd_i.cscan && (ctr_q < C_LIMIT);
  assign d_issue = cmd_i.dscan && (ctr_q < D_LIMIT);
  assign c_idx   = ctr_q[CIW-1:0];
  assign d_idx   = ctr_q[DIW-1:0];
  assign d_raddr = DAW'(slot_q) * D_STRIDE + DAW'(d_idx);

  assign p_cidx  = pidx_q[CIW-1:0];
  assign p_didx  = pidx_q[DIW-1:0];
  assign p_used  = used_q[p_cidx];
  assign c_match = (caddr_rd_q == cmac_q);
  assign d_used  = row_rd_q[p_didx];
  assign d_match = (daddr_rd_q == dmac_q);

  assign sts_o.c_done     = pvld_q && (pidx_q == C_LAST);
  assign sts_o.d_done     = pvld_q && (pidx_q == D_LAST);
  assign sts_o.need_dscan = (op_q == OP_ASSOC) && hit_q;

  assign alloc    = cmd_i.finish_c && (op_q == OP_ASSOC) && !hit_q && free_vld_q;
  assign add_dest = cmd_i.finish_d && !dhit_q && dfree_vld_q;

  // One write port per memory: a new client or a new destination
  assign row_we   = alloc || add_dest;
  assign row_wa   = alloc ? free_q : slot_q;
  assign row_wd   = alloc ? ROW_ONE : (row_rd_q | (ROW_ONE << dfree_q));
  assign daddr_we = alloc || add_dest;
  assign daddr_wa = alloc ? DAW'(free_q) * D_STRIDE
                          : DAW'(slot_q) * D_STRIDE + DAW'(dfree_q);

  assign slot_ext    = {4'b0, slot_q};
  assign free_ext    = {4'b0, free_q};
  assign cnt_ext     = {4'b0, cnt_q};
  assign cnt_inc_ext = {4'b0, CNTW'(cnt_q + 1'b1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      pvld_q      <= 1'b0;
      pidx_q      <= '0;
      used_q      <= '0;
      hit_q       <= 1'b0;
      free_vld_q  <= 1'b0;
      dhit_q      <= 1'b0;
      dfree_vld_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // Advance the walk; the compare runs in the cycle after the read
      if (cmd_i.accept || cmd_i.dstart) begin
        ctr_q  <= '0;
        pvld_q <= 1'b0;
      end else if (c_issue || d_issue) begin
        ctr_q  <= ctr_q + 1'b1;
        pvld_q <= 1'b1;
        pidx_q <= ctr_q;
      end else begin
        pvld_q <= 1'b0;
      end

      if (cmd_i.accept) begin
        hit_q      <= 1'b0;
        free_vld_q <= 1'b0;
      end else if (cmd_i.cscan && pvld_q) begin
        // Lowest matching slot and lowest free slot win
        if (p_used && c_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!p_used && !free_vld_q) begin
          free_vld_q <= 1'b1;
        end
      end

      if (cmd_i.dstart) begin
        dhit_q      <= 1'b0;
        dfree_vld_q <= 1'b0;
        cnt_q       <= '0;
      end else if (cmd_i.dscan && pvld_q) begin
        if (d_used) begin
          cnt_q <= cnt_q + 1'b1;
          if (d_match) begin
            dhit_q <= 1'b1;
          end
        end else if (!dfree_vld_q) begin
          dfree_vld_q <= 1'b1;
        end
      end

      if (cmd_i.finish_c && (op_q == OP_DISASSOC) && hit_q) begin
        used_q[slot_q] <= 1'b0;
      end else if (alloc) begin
        used_q[free_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op_i;
      cmac_q <= in_cmac_i;
      dmac_q <= in_dmac_i;
    end
    if (cmd_i.cscan && pvld_q) begin
      if (p_used && c_match && !hit_q) begin
        slot_q <= p_cidx;
      end
      if (!p_used && !free_vld_q) begin
        free_q <= p_cidx;
      end
    end
    if (cmd_i.dscan && pvld_q && !d_used && !dfree_vld_q) begin
      dfree_q <= p_didx;
    end

    // Client address memory
    if (alloc) begin
      caddr_mem[free_q] <= cmac_q;
    end
    if (c_issue) begin
      caddr_rd_q <= caddr_mem[c_idx];
    end

    // Destination bitmap rows; a row is only read while its client is in use
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (cmd_i.dstart) begin
      row_rd_q <= row_mem[slot_q];
    end

    // Destination address memory
    if (daddr_we) begin
      daddr_mem[daddr_wa] <= dmac_q;
    end
    if (d_issue) begin
      daddr_rd_q <= daddr_mem[d_raddr];
    end

    // Result
    if (cmd_i.finish_c) begin
      if (op_q == OP_DISASSOC) begin
        if (hit_q) begin
          res_status_q <= ST_REMOVED;
          res_slot_q   <= slot_ext[SLOT_W-1:0];
        end else begin
          res_status_q <= ST_NOT_FOUND;
          res_slot_q   <= '0;
        end
        res_count_q <= '0;
      end else if (free_vld_q) begin
        res_status_q <= ST_CLIENT_ADDED;
        res_slot_q   <= free_ext[SLOT_W-1:0];
        res_count_q  <= COUNT_W'(1);
      end else begin
        res_status_q <= ST_FULL;
        res_slot_q   <= '0;
        res_count_q  <= '0;
      end
    end else if (cmd_i.finish_d) begin
      priority if (dhit_q) begin
        res_status_q <= ST_PRESENT;
        res_slot_q   <= slot_ext[SLOT_W-1:0];
        res_count_q  <= cnt_ext[COUNT_W-1:0];
      end else if (!dfree_vld_q) begin
        res_status_q <= ST_FULL;
        res_slot_q   <= '0;
        res_count_q  <= DFULL_EXT[COUNT_W-1:0];
      end else begin
        res_status_q <= ST_DEST_ADDED;
        res_slot_q   <= slot_ext[SLOT_W-1:0];
        res_count_q  <= cnt_inc_ext[COUNT_W-1:0];
      end
    end
  end

  assign res_status_o = res_status_q;
  assign res_slot_o   = res_slot_q;
  assign res_count_o  = res_count_q;

endmodule

// ===== hw/rtl/mat_controller.sv =====
// Controller of the MAC association table: sequences the client walk, the
// destination walk and the result handoff. Depends on mat_pkg.
`timescale 1ns / 1ps

module mat_controller import mat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CSCAN  = 5'b00010,
    S_DECIDE = 5'b00100,
    S_DSCAN  = 5'b01000,
    S_DUPD   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free, load;

  assign out_free = !out_vld_q || m_ready_i;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CSCAN;
        end
      end
      S_CSCAN: begin
        cmd_o.cscan = 1'b1;
        if (sts_i.c_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.need_dscan) begin
          cmd_o.dstart = 1'b1;
          state_d      = S_DSCAN;
        end else if (out_free) begin
          cmd_o.finish_c = 1'b1;
          load           = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DSCAN: begin
        cmd_o.dscan = 1'b1;
        if (sts_i.d_done) begin
          state_d = S_DUPD;
        end
      end
      S_DUPD: begin
        // Hold the commit until the output register is free
        if (out_free) begin
          cmd_o.finish_d = 1'b1;
          load           = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_vld_d = load ? 1'b1 : (m_ready_i ? 1'b0 : out_vld_q);
  assign m_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== hw/rtl/mac_association_table.sv =====
// Top level of the MAC association table: stream ports, controller and
// datapath. Depends on mat_pkg, mat_controller and mat_datapath.
`timescale 1ns / 1ps

// Keeps up to CLIENT_SLOTS client MAC addresses, each with a set of up to
// DESTS_PER_CLIENT distinct destination MACs. An associate beat (tuser 0)
// finds the client, or takes the lowest free slot for it, and adds the
// destination unless it is already there; a disassociate beat (tuser 1) drops
// the client with all its destinations. Every input beat gives exactly one
// output beat with a status (client added, destination added, already
// present, client removed, not found, full), the slot touched and the
// destination count after the operation. One item is worked at a time: the
// client address memory is walked one slot per cycle, and an item that ends
// at the client level (disassociate, new client, client table full) loads
// its result once that walk is done, while an associate of a known client
// then walks its destination row one entry per cycle. The next beat can be
// accepted in the cycle right after the result is loaded. A finished result
// waits in the output register while the next item is accepted and walked;
// the next result holds its load until that register is free.
// Slot valid bits clear at reset, so the table is usable right away.

module mac_association_table import mat_pkg::*; #(
  parameter int unsigned CLIENT_SLOTS     = 16,
  parameter int unsigned DESTS_PER_CLIENT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [47:0] client_mac, [95:48] dest_mac
  input  logic [0:0]  s_axis_tuser,   // [0] op
  // Result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] client_slot, [7:4] dest_count
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  cmd_t                cmd;
  sts_t                sts;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [COUNT_W-1:0]  res_count;

  // Sequencing: accept, walk clients, decide, optionally walk destinations
  mat_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Storage, compares and the result register
  mat_datapath #(
    .CLIENT_SLOTS     (CLIENT_SLOTS),
    .DESTS_PER_CLIENT (DESTS_PER_CLIENT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser[0]),
    .in_cmac_i    (s_axis_tdata[MAC_W-1:0]),
    .in_dmac_i    (s_axis_tdata[2*MAC_W-1:MAC_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_status_o (res_status),
    .res_slot_o   (res_slot),
    .res_count_o  (res_count)
  );

  assign m_axis_tdata = {res_count, res_slot};
  assign m_axis_tuser = res_status;

endmodule

// ===== hw/rtl/mat_checker.sv =====
// Port-level checks for the MAC association table, bound to the top level.
// Depends on mat_pkg and mac_association_table.
`timescale 1ns / 1ps

module mat_checker import mat_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // One item at a time: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // A new result only appears at the end of an item's work
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result beat without an item in progress");

  // Full and not-found results carry no slot; removal or not-found leaves no destinations
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FOUND) |->
      m_axis_tdata[3:0] == 4'd0)
    else $error("slot reported for a full or not-found result");

  a_removed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_REMOVED || m_axis_tuser == ST_NOT_FOUND) |->
      m_axis_tdata[7:4] == 4'd0)
    else $error("destinations reported for a removed or unknown client");

endmodule

bind mac_association_table mat_checker u_mat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
